[hdl/v3n_pkg.sv]
package v3n_pkg;

  // Fixed formats of the datapath
  localparam int CompW  = 32;                 // Q16.16 component width
  localparam int SumW   = 2 * CompW;          // sum of squares
  localparam int RootW  = CompW;              // truncated length
  localparam int QuotW  = CompW - 1;          // quotient magnitude, at most 2^30
  localparam int FracW  = 30;                 // Q2.30 fraction bits
  localparam logic [CompW-1:0] UNIT_ONE = 32'h4000_0000;

  // One classified vector travelling from front to back
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [CompW-1:0] mag_x;
    logic [CompW-1:0] mag_y;
    logic [CompW-1:0] mag_z;
    logic [2:0]       neg;     // {z, y, x}
    logic             zero;
  } v3n_item_t;

endpackage

[hdl/vector3_normalize.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | in_vec_x, in_vec_y, in_vec_z (s Q16.16)
// result   | out_valid/out_ready  | out_unit_x/y/z (s Q2.30), out_vec_length,
//          |                      | out_zero_length
//
// One vector per cycle sustained while out_ready allows. A result passes
// through 3 front stages, the queue, a root input register and 32 root
// stages (one root bit each), a divider input register and 31 divider
// stages (one quotient bit each), then the output register.
// Synchronous active-low reset clears all valid bits and the queue pointers.
// The back stalls only on out_ready; the front keeps accepting until the
// queue fills.
module vector3_normalize #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_unit_x,
  output logic signed [31:0] out_unit_y,
  output logic signed [31:0] out_unit_z,
  output logic [31:0]        out_vec_length,
  output logic               out_zero_length
);
  import v3n_pkg::*;

  logic      push, pop, q_full, q_empty;
  v3n_item_t push_item, pop_item;

  v3n_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_vec_x, .in_vec_y, .in_vec_z,
    .push, .push_item, .q_full
  );

  v3n_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .push_item, .full(q_full),
    .pop, .empty(q_empty), .pop_item
  );

  v3n_back u_back (
    .clk, .rst_n, .q_empty, .pop, .pop_item, .out_valid, .out_ready,
    .out_unit_x, .out_unit_y, .out_unit_z, .out_vec_length, .out_zero_length
  );

  // zero flag agrees with the computed length
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_length == (out_vec_length == 32'd0)))
    else $error("zero flag and length disagree");

  // zero vector gives (0,0,1)
  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_unit_x == 32'sd0 && out_unit_y == 32'sd0 && out_unit_z == UNIT_ONE))
    else $error("zero vector result is not (0,0,1)");

  // x and y unit components stay within [-1.0, 1.0]
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_unit_x <= 32'sh4000_0000 && out_unit_x >= -32'sh4000_0000 &&
                   out_unit_y <= 32'sh4000_0000 && out_unit_y >= -32'sh4000_0000))
    else $error("unit component out of range");

endmodule

[hdl/v3n_front.sv]
module v3n_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               push,
  output v3n_pkg::v3n_item_t push_item,
  input  logic               q_full
);
  import v3n_pkg::*;

  logic             s1_v_r, s2_v_r, s3_v_r;
  logic             en;
  logic [CompW-1:0] s1_mx_r, s1_my_r, s1_mz_r;
  logic [2:0]       s1_neg_r, s2_neg_r;
  logic             s1_zero_r, s2_zero_r;
  logic [CompW-1:0] s2_mx_r, s2_my_r, s2_mz_r;
  logic [SumW-1:0]  s2_sqx_r, s2_sqy_r, s2_sqz_r;
  v3n_item_t        s3_item_r;

  // Whole front advances together unless the last stage is blocked
  assign en        = !s3_v_r || !q_full;
  assign in_ready  = en;
  assign push      = s3_v_r && !q_full;
  assign push_item = s3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: magnitudes, signs, zero classification
      s1_mx_r   <= in_vec_x[31] ? (~in_vec_x + 32'd1) : in_vec_x;
      s1_my_r   <= in_vec_y[31] ? (~in_vec_y + 32'd1) : in_vec_y;
      s1_mz_r   <= in_vec_z[31] ? (~in_vec_z + 32'd1) : in_vec_z;
      s1_neg_r  <= {in_vec_z[31], in_vec_y[31], in_vec_x[31]};
      s1_zero_r <= (in_vec_x == 32'sd0) && (in_vec_y == 32'sd0) && (in_vec_z == 32'sd0);
      // stage 2: squares
      s2_sqx_r  <= SumW'(s1_mx_r) * SumW'(s1_mx_r);
      s2_sqy_r  <= SumW'(s1_my_r) * SumW'(s1_my_r);
      s2_sqz_r  <= SumW'(s1_mz_r) * SumW'(s1_mz_r);
      s2_mx_r   <= s1_mx_r;
      s2_my_r   <= s1_my_r;
      s2_mz_r   <= s1_mz_r;
      s2_neg_r  <= s1_neg_r;
      s2_zero_r <= s1_zero_r;
      // stage 3: sum of squares
      s3_item_r.sum   <= s2_sqx_r + s2_sqy_r + s2_sqz_r;
      s3_item_r.mag_x <= s2_mx_r;
      s3_item_r.mag_y <= s2_my_r;
      s3_item_r.mag_z <= s2_mz_r;
      s3_item_r.neg   <= s2_neg_r;
      s3_item_r.zero  <= s2_zero_r;
    end
  end

endmodule

[hdl/v3n_fifo.sv]
module v3n_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  v3n_pkg::v3n_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output v3n_pkg::v3n_item_t pop_item
);
  import v3n_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  v3n_item_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers wrap at DEPTH
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hdl/v3n_div.sv]
module v3n_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag,
  input  logic [31:0] len,
  output logic [30:0] quot
);
  import v3n_pkg::*;

  // (mag << 30) / len, one quotient bit per stage. The top 31 dividend bits
  // (mag >> 1) are already below len, so only the low 31 bits are shifted in.
  localparam int Steps = QuotW;

  logic [31:0]      rem_r  [Steps+1];
  logic [Steps-1:0] dvd_r  [Steps+1];
  logic [Steps-1:0] q_r    [Steps+1];
  logic [31:0]      len_r  [Steps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, mag[31:1]};
      dvd_r[0] <= {mag[0], {FracW{1'b0}}};
      q_r[0]   <= '0;
      len_r[0] <= len;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[k], dvd_r[k][Steps-1]};
    assign ge    = (trial >= {1'b0, len_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? 32'(trial - {1'b0, len_r[k]}) : trial[31:0];
        dvd_r[k+1] <= {dvd_r[k][Steps-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][Steps-2:0], ge};
        len_r[k+1] <= len_r[k];
      end
    end
  end

  assign quot = q_r[Steps];

endmodule

[hdl/v3n_back.sv]
module v3n_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               pop,
  input  v3n_pkg::v3n_item_t pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_unit_x,
  output logic signed [31:0] out_unit_y,
  output logic signed [31:0] out_unit_z,
  output logic [31:0]        out_vec_length,
  output logic               out_zero_length
);
  import v3n_pkg::*;

  localparam int SqSteps  = RootW;
  localparam int DivSteps = QuotW;

  logic en;

  // square root line: one root bit per stage
  logic              sq_v_r    [SqSteps+1];
  logic [SumW-1:0]   sq_n_r    [SqSteps+1];
  logic [RootW+1:0]  sq_rem_r  [SqSteps+1];
  logic [RootW-1:0]  sq_root_r [SqSteps+1];
  v3n_item_t         sq_item_r [SqSteps+1];

  // side data alongside the dividers
  logic              dv_v_r    [DivSteps+1];
  logic [2:0]        dv_neg_r  [DivSteps+1];
  logic              dv_zero_r [DivSteps+1];
  logic [RootW-1:0]  dv_len_r  [DivSteps+1];

  logic [QuotW-1:0]  qx, qy, qz;
  logic              out_v_r;
  logic [31:0]       ux_r, uy_r, uz_r, len_out_r;
  logic              zero_out_r;

  // back stalls as a whole on the output register
  assign en  = !out_v_r || out_ready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n_r[0]    <= pop_item.sum;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_item_r[0] <= pop_item;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    logic [RootW+3:0] tmp, trial;
    logic             ge;
    assign tmp   = {sq_rem_r[k], sq_n_r[k][SumW-1 -: 2]};
    assign trial = {2'b00, sq_root_r[k], 2'b01};
    assign ge    = (tmp >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= ge ? (RootW+2)'(tmp - trial) : tmp[RootW+1:0];
        sq_root_r[k+1] <= {sq_root_r[k][RootW-2:0], ge};
        sq_n_r[k+1]    <= {sq_n_r[k][SumW-3:0], 2'b00};
        sq_item_r[k+1] <= sq_item_r[k];
      end
    end
  end

  // three divider lanes, shared length
  v3n_div u_div_x (.clk(clk), .en(en), .mag(sq_item_r[SqSteps].mag_x),
                   .len(sq_root_r[SqSteps]), .quot(qx));
  v3n_div u_div_y (.clk(clk), .en(en), .mag(sq_item_r[SqSteps].mag_y),
                   .len(sq_root_r[SqSteps]), .quot(qy));
  v3n_div u_div_z (.clk(clk), .en(en), .mag(sq_item_r[SqSteps].mag_z),
                   .len(sq_root_r[SqSteps]), .quot(qz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SqSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_neg_r[0]  <= sq_item_r[SqSteps].neg;
      dv_zero_r[0] <= sq_item_r[SqSteps].zero;
      dv_len_r[0]  <= sq_root_r[SqSteps];
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_len_r[k+1]  <= dv_len_r[k];
      end
    end
  end

  // output register: sign fix-up and zero-vector override
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_zero_r[DivSteps]) begin
        ux_r      <= '0;
        uy_r      <= '0;
        uz_r      <= UNIT_ONE;
        len_out_r <= '0;
      end else begin
        ux_r      <= dv_neg_r[DivSteps][0] ? (~{1'b0, qx} + 32'd1) : {1'b0, qx};
        uy_r      <= dv_neg_r[DivSteps][1] ? (~{1'b0, qy} + 32'd1) : {1'b0, qy};
        uz_r      <= dv_neg_r[DivSteps][2] ? (~{1'b0, qz} + 32'd1) : {1'b0, qz};
        len_out_r <= dv_len_r[DivSteps];
      end
      zero_out_r <= dv_zero_r[DivSteps];
    end
  end

  assign out_valid       = out_v_r;
  assign out_unit_x      = ux_r;
  assign out_unit_y      = uy_r;
  assign out_unit_z      = uz_r;
  assign out_vec_length  = len_out_r;
  assign out_zero_length = zero_out_r;

endmodule
